>>> rtl/gic_pkg.sv
package gic_pkg;

  localparam int AXIS_W   = 16;
  localparam int DZ_W     = 15;
  localparam int TRIG_W   = 8;
  localparam int BTN_W    = 16;
  localparam int MAG_W    = 15;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_LEFT_DEADZONE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_DEADZONE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRIG_THRESHOLD = 2'd2;

  localparam logic [DZ_W-1:0]   LEFT_DZ_RESET  = 15'd7849;
  localparam logic [DZ_W-1:0]   RIGHT_DZ_RESET = 15'd8689;
  localparam logic [TRIG_W-1:0] TRIG_RESET     = 8'd30;

  localparam logic [DZ_W-1:0] LIMIT_MAG = 15'd32767;
  localparam logic [31:0]     LIMIT_MAG_SQ = 32'd1073676289;

  localparam logic [1:0] JOB_DIR_X = 2'd0;
  localparam logic [1:0] JOB_DIR_Y = 2'd1;
  localparam logic [1:0] JOB_MAG   = 2'd2;

  // magnitude of a signed axis, -32768 gives 32768
  function automatic logic [AXIS_W:0] axis_abs(input logic [AXIS_W-1:0] a);
    logic [AXIS_W:0] e;
    e = {a[AXIS_W-1], a};
    return a[AXIS_W-1] ? (~e + 17'd1) : e;
  endfunction

endpackage

>>> rtl/gamepad_input_conditioner_core.sv
// Gamepad input conditioner. One polled sample per word in, one conditioned word out.
// Button edges and trigger thresholds are ready at once; the stick work runs on one
// shared subtract/compare unit under a sequencer: per stick five squarings and one
// sum step, then for each direction component a setup step, a 33-step restoring
// divide and a 17-step square root, and for the magnitude a setup step, a 32-step
// square root, a 16-step divide, a rounding step and a hand-off step. in_stall stays
// high from the moment a sample is taken until the result word is loaded, so no new
// sample is accepted before the last one is through; an axis inside the deadzone
// skips its divide and square root, and a clipped or zero magnitude skips its square
// root and divide. A result word still stalled at the output holds the sequencer
// until it is taken. Write configuration only while idle.
module gamepad_input_conditioner_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] buttons,
  input  logic [7:0]  left_trigger,
  input  logic [7:0]  right_trigger,
  input  logic signed [15:0] left_x,
  input  logic signed [15:0] left_y,
  input  logic signed [15:0] right_x,
  input  logic signed [15:0] right_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] pressed_mask,
  output logic [15:0] released_mask,
  output logic [7:0]  left_trigger_force,
  output logic [7:0]  right_trigger_force,
  output logic signed [15:0] left_dir_x,
  output logic signed [15:0] left_dir_y,
  output logic signed [15:0] right_dir_x,
  output logic signed [15:0] right_dir_y,
  output logic [14:0] left_magnitude,
  output logic [14:0] right_magnitude,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_data
);
  import gic_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQ   = 3'd1;
  localparam logic [2:0] ST_PREP = 3'd2;
  localparam logic [2:0] ST_JOB  = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_SQRT = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  logic [2:0]  state;
  logic [2:0]  sqi;
  logic [1:0]  job;
  logic        stick;
  logic [5:0]  cnt;

  logic [DZ_W-1:0]   left_dz, right_dz;
  logic [TRIG_W-1:0] trig_th;
  logic [BTN_W-1:0]  prev_buttons;

  logic [15:0] lx, ly, rx, ry;
  logic [15:0] w_pressed, w_released;
  logic [7:0]  w_lt, w_rt;
  logic [15:0] w_ldx, w_ldy, w_rdx, w_rdy;
  logic [14:0] w_lmag, w_rmag;

  logic [30:0] ax2, ay2, rx2, ry2, dz2;
  logic [31:0] m2d, m2r;

  logic [31:0] rem;
  logic [32:0] dlo;
  logic [31:0] dv;
  logic [32:0] quo;
  logic [63:0] rad;
  logic [33:0] srem;
  logic [31:0] root;

  logic [15:0] sx, sy;
  logic [DZ_W-1:0] dz;
  logic [16:0] ax_abs, ay_abs, dzx, dzy, mul_a;
  logic [33:0] mul_p;
  logic [35:0] sub_a, sub_b, sub_d;
  logic        sub_ge;
  logic        comp_neg;
  logic [17:0] lo_inc;
  logic [15:0] q16, comp;
  logic [17:0] mlo_inc;
  logic [14:0] mag_r;
  logic        in_acc;
  logic        quo_live;
  logic        out_load;

  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  assign sx = stick ? rx : lx;
  assign sy = stick ? ry : ly;
  assign dz = stick ? right_dz : left_dz;
  assign ax_abs = axis_abs(sx);
  assign ay_abs = axis_abs(sy);
  assign dzx = (ax_abs < {2'b00, dz}) ? 17'd0 : ax_abs;
  assign dzy = (ay_abs < {2'b00, dz}) ? 17'd0 : ay_abs;

  always_comb begin
    case (sqi)
      3'd0:    mul_a = dzx;
      3'd1:    mul_a = dzy;
      3'd2:    mul_a = ax_abs;
      3'd3:    mul_a = ay_abs;
      default: mul_a = {2'b00, dz};
    endcase
  end
  assign mul_p = mul_a * mul_a;

  // shared trial subtract: divide step or square-root step
  always_comb begin
    if (state == ST_DIV) begin
      sub_a = {3'b000, rem, dlo[32]};
      sub_b = {4'b0000, dv};
    end else begin
      sub_a = {srem, rad[63:62]};
      sub_b = {2'b00, root, 2'b01};
    end
  end
  assign sub_d  = sub_a - sub_b;
  assign sub_ge = (sub_a >= sub_b);

  // direction component from the finished square root, rounded and signed
  assign comp_neg = (job == JOB_DIR_X) ? sx[15] : (!sy[15] && (sy != 16'd0));
  assign lo_inc = {1'b0, root[15:0], sub_ge} + 18'd1;
  assign q16 = lo_inc[16:1];
  always_comb begin
    if (comp_neg) comp = ~q16 + 16'd1;
    else if (q16[15]) comp = 16'h7FFF;
    else comp = q16;
  end

  assign mlo_inc = {1'b0, quo[16:0]} + 18'd1;
  assign mag_r = (mlo_inc[17:1] > 17'd32767) ? 15'h7FFF : mlo_inc[15:1];

  assign out_load = (state == ST_DONE) && stick && !quo_live && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      left_dz      <= LEFT_DZ_RESET;
      right_dz     <= RIGHT_DZ_RESET;
      trig_th      <= TRIG_RESET;
      prev_buttons <= '0;
      state        <= ST_IDLE;
      out_valid    <= 1'b0;
      sqi          <= '0;
      job          <= JOB_DIR_X;
      stick        <= 1'b0;
      cnt          <= '0;
      quo_live     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LEFT_DEADZONE:  left_dz <= cfg_data;
          REG_RIGHT_DEADZONE: right_dz <= cfg_data;
          REG_TRIG_THRESHOLD: trig_th <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (out_load) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            w_pressed    <= buttons & ~prev_buttons;
            w_released   <= ~buttons & prev_buttons;
            prev_buttons <= buttons;
            w_lt <= (left_trigger < trig_th) ? 8'd0 : left_trigger;
            w_rt <= (right_trigger < trig_th) ? 8'd0 : right_trigger;
            lx <= left_x;
            ly <= left_y;
            rx <= right_x;
            ry <= right_y;
            stick <= 1'b0;
            sqi   <= 3'd0;
            state <= ST_SQ;
          end
        end
        ST_SQ: begin
          case (sqi)
            3'd0:    ax2 <= mul_p[30:0];
            3'd1:    ay2 <= mul_p[30:0];
            3'd2:    rx2 <= mul_p[30:0];
            3'd3:    ry2 <= mul_p[30:0];
            default: dz2 <= mul_p[30:0];
          endcase
          if (sqi == 3'd4) state <= ST_PREP;
          sqi <= sqi + 3'd1;
        end
        ST_PREP: begin
          m2d   <= {1'b0, ax2} + {1'b0, ay2};
          m2r   <= {1'b0, rx2} + {1'b0, ry2};
          job   <= JOB_DIR_X;
          state <= ST_JOB;
        end
        ST_JOB: begin
          if (job == JOB_MAG) begin
            if ((dz == LIMIT_MAG) || (m2r <= {1'b0, dz2}) || (m2r >= LIMIT_MAG_SQ)) begin
              if ((dz == LIMIT_MAG) || (m2r <= {1'b0, dz2})) begin
                if (stick) w_rmag <= '0; else w_lmag <= '0;
              end else begin
                if (stick) w_rmag <= 15'h7FFF; else w_lmag <= 15'h7FFF;
              end
              // advance to the next stick or finish
              if (!stick) begin
                stick <= 1'b1;
                sqi   <= 3'd0;
                state <= ST_SQ;
              end else begin
                state <= ST_DONE;
              end
            end else begin
              rad   <= {m2r, 32'd0};
              srem  <= '0;
              root  <= '0;
              cnt   <= 6'd32;
              state <= ST_SQRT;
            end
          end else begin
            if (((job == JOB_DIR_X) ? ax2 : ay2) == 31'd0) begin
              case ({stick, job[0]})
                2'b00:   w_ldx <= '0;
                2'b01:   w_ldy <= '0;
                2'b10:   w_rdx <= '0;
                default: w_rdy <= '0;
              endcase
              job <= job + 2'd1;
            end else begin
              rem   <= {2'b00, ((job == JOB_DIR_X) ? ax2[30:1] : ay2[30:1])};
              dlo   <= {((job == JOB_DIR_X) ? ax2[0] : ay2[0]), 32'd0};
              dv    <= m2d;
              quo   <= '0;
              cnt   <= 6'd33;
              state <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (sub_ge) rem <= sub_d[31:0];
          else rem <= sub_a[31:0];
          dlo <= {dlo[31:0], 1'b0};
          quo <= {quo[31:0], sub_ge};
          if (cnt == 6'd1) begin
            if (job == JOB_MAG) begin
              quo_live <= 1'b1;
              state    <= ST_DONE;
            end else begin
              rad   <= {1'b0, quo[31:0], sub_ge, 30'd0};
              srem  <= '0;
              root  <= '0;
              cnt   <= 6'd17;
              state <= ST_SQRT;
            end
          end else begin
            cnt <= cnt - 6'd1;
          end
        end
        ST_SQRT: begin
          if (sub_ge) srem <= sub_d[33:0];
          else srem <= sub_a[33:0];
          root <= {root[30:0], sub_ge};
          rad  <= {rad[61:0], 2'b00};
          if (cnt == 6'd1) begin
            if (job == JOB_MAG) begin
              // divide (S - dz<<16) by (32767 - dz), S being the root
              rem   <= {16'd0, (root[30:15] - {1'b0, dz})};
              dlo   <= {root[14:0], sub_ge, 17'd0};
              dv    <= {17'd0, LIMIT_MAG - dz};
              quo   <= '0;
              cnt   <= 6'd16;
              state <= ST_DIV;
            end else begin
              state <= ST_JOB;
              job   <= job + 2'd1;
            end
          end else begin
            cnt <= cnt - 6'd1;
          end
        end
        ST_DONE: begin
          if (quo_live) begin
            // round the magnitude quotient
            if (stick) w_rmag <= mag_r; else w_lmag <= mag_r;
            quo_live <= 1'b0;
          end else if (!stick) begin
            stick <= 1'b1;
            sqi   <= 3'd0;
            state <= ST_SQ;
          end else if (out_load) begin
            pressed_mask        <= w_pressed;
            released_mask       <= w_released;
            left_trigger_force  <= w_lt;
            right_trigger_force <= w_rt;
            left_dir_x          <= w_ldx;
            left_dir_y          <= w_ldy;
            right_dir_x         <= w_rdx;
            right_dir_y         <= w_rdy;
            left_magnitude      <= w_lmag;
            right_magnitude     <= w_rmag;
            state               <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase

      // capture finished results of the iterations
      if (state == ST_SQRT && cnt == 6'd1 && job != JOB_MAG) begin
        case ({stick, job[0]})
          2'b00:   w_ldx <= comp;
          2'b01:   w_ldy <= comp;
          2'b10:   w_rdx <= comp;
          default: w_rdy <= comp;
        endcase
      end
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (state == ST_SQ))
    else $error("sample accepted but sequencer did not start");

  a_iter_count: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_DIV) || (state == ST_SQRT)) |-> (cnt != 6'd0))
    else $error("iteration running with zero step count");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (dv != 32'd0))
    else $error("divide started with zero divisor");

endmodule
